// File: hdl/fdld_pkg.sv
// Shared types, constants and the stencil decoder for the line derivative block.
// No dependencies; every other file in hdl/ imports this package.
package fdld_pkg;

	localparam int SAMPLE_BITS  = 32;
	localparam int MAX_LINE     = 65535;
	localparam int STENCIL_TAPS = 5;

	// Configuration register indexes.
	localparam logic [2:0] REG_ORDER    = 3'd0;
	localparam logic [2:0] REG_PERIODIC = 3'd1;
	localparam logic [2:0] REG_COMBINE  = 3'd2;
	localparam logic [2:0] REG_SCALE    = 3'd3;
	localparam logic [2:0] REG_LENGTH   = 3'd4;

	// Combine modes; the unused code behaves as a plain write.
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_ADD   = 2'd1;
	localparam logic [1:0] MODE_SUB   = 2'd2;

	// Largest scaled magnitude, 2^40.
	localparam logic [49:0] R_LIMIT = 50'd1 << 40;

	typedef struct packed {
		logic signed [31:0] sample;
		logic signed [31:0] prior_out;
	} item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic        [15:0] position;
		logic               last_of_run;
		logic               error;
	} result_t;

	typedef struct packed {
		logic        order_select;
		logic        periodic;
		logic [1:0]  combine_mode;
		logic [31:0] scale;
		logic [15:0] line_length;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		order_select: 1'b1,
		periodic:     1'b0,
		combine_mode: MODE_WRITE,
		scale:        32'd65536,
		line_length:  16'd64
	};

	// One stencil evaluation; each kind fixes operands, weights, prior and position.
	typedef enum logic [3:0] {
		KIND_ERR,
		KIND_E2L,
		KIND_C2,
		KIND_E2R,
		KIND_P2A,
		KIND_P2B,
		KIND_E4L0,
		KIND_E4L1,
		KIND_C4,
		KIND_E4R0,
		KIND_E4R1,
		KIND_P4A,
		KIND_P4B,
		KIND_P4C,
		KIND_P4D
	} job_kind_t;

	typedef struct packed {
		logic signed [31:0] prior;
		logic        [15:0] pos;
		logic               err;
		logic               last;
	} meta_t;

	typedef struct packed {
		logic [4:0][31:0] x;
		logic [4:0][6:0]  w;
		meta_t            meta;
	} job_t;

	typedef struct packed {
		logic signed [39:0] num;
		meta_t              meta;
	} sum_t;

	typedef struct packed {
		logic [40:0] r;
		logic        neg;
		meta_t       meta;
	} mag_t;

	// Maps a stencil kind onto five weighted operands taken from the sample
	// window (index 0 newest), the head samples and the prior values.
	function automatic job_t build_job(
		job_kind_t        kind,
		logic [4:0][31:0] sw,
		logic [3:0][31:0] hs,
		logic [2:0][31:0] pw,
		logic [1:0][31:0] hp,
		logic [15:0]      k
	);
		job_t j;
		j = '0;
		j.meta.pos = k;
		unique case (kind)
			KIND_ERR: begin
				j.meta.err = 1'b1;
			end
			KIND_E2L: begin
				j.x[0] = sw[2]; j.w[0] = 7'(-3);
				j.x[1] = sw[1]; j.w[1] = 7'(4);
				j.x[2] = sw[0]; j.w[2] = 7'(-1);
				j.meta.prior = hp[0];
				j.meta.pos = 16'd0;
			end
			KIND_C2: begin
				j.x[0] = sw[0]; j.w[0] = 7'(1);
				j.x[1] = sw[2]; j.w[1] = 7'(-1);
				j.meta.prior = pw[1];
				j.meta.pos = k - 16'd1;
			end
			KIND_E2R: begin
				j.x[0] = sw[0]; j.w[0] = 7'(3);
				j.x[1] = sw[1]; j.w[1] = 7'(-4);
				j.x[2] = sw[2]; j.w[2] = 7'(1);
				j.meta.prior = pw[0];
			end
			KIND_P2A: begin
				j.x[0] = hs[0]; j.w[0] = 7'(1);
				j.x[1] = sw[1]; j.w[1] = 7'(-1);
				j.meta.prior = pw[0];
			end
			KIND_P2B: begin
				j.x[0] = hs[1]; j.w[0] = 7'(1);
				j.x[1] = sw[0]; j.w[1] = 7'(-1);
				j.meta.prior = hp[0];
				j.meta.pos = 16'd0;
			end
			KIND_E4L0: begin
				j.x = sw;
				j.w[0] = 7'(-3); j.w[1] = 7'(16); j.w[2] = 7'(-36);
				j.w[3] = 7'(48); j.w[4] = 7'(-25);
				j.meta.prior = hp[0];
				j.meta.pos = 16'd0;
			end
			KIND_E4L1: begin
				j.x = sw;
				j.w[0] = 7'(1); j.w[1] = 7'(-6); j.w[2] = 7'(18);
				j.w[3] = 7'(-10); j.w[4] = 7'(-3);
				j.meta.prior = hp[1];
				j.meta.pos = 16'd1;
			end
			KIND_C4: begin
				j.x[0] = sw[0]; j.w[0] = 7'(-1);
				j.x[1] = sw[1]; j.w[1] = 7'(8);
				j.x[2] = sw[3]; j.w[2] = 7'(-8);
				j.x[3] = sw[4]; j.w[3] = 7'(1);
				j.meta.prior = pw[2];
				j.meta.pos = k - 16'd2;
			end
			KIND_E4R0: begin
				j.x = sw;
				j.w[0] = 7'(3); j.w[1] = 7'(10); j.w[2] = 7'(-18);
				j.w[3] = 7'(6); j.w[4] = 7'(-1);
				j.meta.prior = pw[1];
				j.meta.pos = k - 16'd1;
			end
			KIND_E4R1: begin
				j.x = sw;
				j.w[0] = 7'(25); j.w[1] = 7'(-48); j.w[2] = 7'(36);
				j.w[3] = 7'(-16); j.w[4] = 7'(3);
				j.meta.prior = pw[0];
			end
			KIND_P4A: begin
				j.x[0] = hs[0]; j.w[0] = 7'(-1);
				j.x[1] = sw[0]; j.w[1] = 7'(8);
				j.x[2] = sw[2]; j.w[2] = 7'(-8);
				j.x[3] = sw[3]; j.w[3] = 7'(1);
				j.meta.prior = pw[1];
				j.meta.pos = k - 16'd1;
			end
			KIND_P4B: begin
				j.x[0] = hs[1]; j.w[0] = 7'(-1);
				j.x[1] = hs[0]; j.w[1] = 7'(8);
				j.x[2] = sw[1]; j.w[2] = 7'(-8);
				j.x[3] = sw[2]; j.w[3] = 7'(1);
				j.meta.prior = pw[0];
			end
			KIND_P4C: begin
				j.x[0] = hs[2]; j.w[0] = 7'(-1);
				j.x[1] = hs[1]; j.w[1] = 7'(8);
				j.x[2] = sw[0]; j.w[2] = 7'(-8);
				j.x[3] = sw[1]; j.w[3] = 7'(1);
				j.meta.prior = hp[0];
				j.meta.pos = 16'd0;
			end
			KIND_P4D: begin
				j.x[0] = hs[3]; j.w[0] = 7'(-1);
				j.x[1] = hs[2]; j.w[1] = 7'(8);
				j.x[2] = hs[0]; j.w[2] = 7'(-8);
				j.x[3] = sw[0]; j.w[3] = 7'(1);
				j.meta.prior = hp[1];
				j.meta.pos = 16'd1;
			end
			default: begin
				j.meta.err = 1'b1;
			end
		endcase
		return j;
	endfunction

endpackage

// File: hdl/fdld_regs.sv
// Configuration register file for the line derivative block.
// Depends on fdld_pkg for the register indexes, reset values and cfg_t.
module fdld_regs (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [31:0]    cfg_data,
	output fdld_pkg::cfg_t cfg
);
	import fdld_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ORDER:    cfg_q.order_select <= cfg_data[0];
				REG_PERIODIC: cfg_q.periodic     <= cfg_data[0];
				REG_COMBINE:  cfg_q.combine_mode <= cfg_data[1:0];
				REG_SCALE:    cfg_q.scale        <= cfg_data;
				REG_LENGTH:   cfg_q.line_length  <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// File: hdl/fdld_front.sv
// Input stage: sample and prior windows, line position, stencil list per item
// and the issue sequencer with the held fifth result. Depends on fdld_pkg.
module fdld_front (
	input  logic            clk,
	input  logic            arst_n,
	input  fdld_pkg::cfg_t  cfg,
	input  logic            item_valid,
	output logic            item_stall,
	input  fdld_pkg::item_t item,
	output logic            job_valid,
	input  logic            job_ready,
	output fdld_pkg::job_t  job
);
	import fdld_pkg::*;

	// Line state.
	logic [4:0][31:0] sw_q;
	logic [2:0][31:0] pw_q;
	logic [3:0][31:0] hs_q;
	logic [1:0][31:0] hp_q;
	logic [15:0]      pos_q;

	// Step register: the stencil list of the last accepted item.
	logic             step_v_s1;
	job_kind_t        kinds_s1 [5];
	logic [2:0]       n_s1;
	logic             held_s1;
	logic [15:0]      k_s1;
	logic [1:0]       j_s1;

	// Fifth result of a step, waiting for the next item.
	logic             held_v_q;
	job_t             held_q;

	logic signed [31:0] sample_ext;
	logic [15:0]      len;
	logic [15:0]      min_len;
	logic [15:0]      two_h;
	logic             at_last;
	logic             short_line;
	job_kind_t        list [5];
	logic [2:0]       cnt;
	logic             accept;
	logic [2:0]       tot;
	logic [2:0]       nret;
	logic             use_held;
	logic [2:0]       idx;
	logic [2:0]       idx4;
	logic             is_final;
	logic             fire;
	logic             done;
	logic             held_set;
	logic             held_clr;
	logic             held_v_d;

	assign sample_ext = 32'($signed(item.sample[SAMPLE_BITS-1:0]));

	always_comb begin
		len = (32'(cfg.line_length) > MAX_LINE) ? 16'(MAX_LINE) : cfg.line_length;
		if (cfg.order_select) begin
			min_len = cfg.periodic ? 16'd4 : 16'd5;
			two_h = 16'd4;
		end else begin
			min_len = 16'd3;
			two_h = 16'd2;
		end
		short_line = len < min_len;
		at_last = ({1'b0, pos_q} + 17'd1) >= {1'b0, len};
	end

	// Stencils finished by this item, in the order they leave.
	always_comb begin
		list = '{default: KIND_ERR};
		cnt = '0;
		if (short_line) begin
			list[0] = KIND_ERR;
			cnt = 3'd1;
		end else begin
			if (!cfg.periodic && pos_q == two_h) begin
				if (cfg.order_select) begin
					list[0] = KIND_E4L0;
					list[1] = KIND_E4L1;
					cnt = 3'd2;
				end else begin
					list[0] = KIND_E2L;
					cnt = 3'd1;
				end
			end
			if (pos_q >= two_h) begin
				list[cnt] = cfg.order_select ? KIND_C4 : KIND_C2;
				cnt = cnt + 3'd1;
			end
			if (at_last) begin
				if (!cfg.order_select) begin
					if (!cfg.periodic) begin
						list[cnt] = KIND_E2R;
						cnt = cnt + 3'd1;
					end else begin
						list[cnt] = KIND_P2A;
						list[cnt + 3'd1] = KIND_P2B;
						cnt = cnt + 3'd2;
					end
				end else if (!cfg.periodic) begin
					list[cnt] = KIND_E4R0;
					list[cnt + 3'd1] = KIND_E4R1;
					cnt = cnt + 3'd2;
				end else begin
					list[cnt] = KIND_P4A;
					list[cnt + 3'd1] = KIND_P4B;
					list[cnt + 3'd2] = KIND_P4C;
					list[cnt + 3'd3] = KIND_P4D;
					cnt = cnt + 3'd4;
				end
			end
		end
	end

	// Issue sequencer: a held result goes first, at most four leave per step.
	always_comb begin
		tot = n_s1 + {2'b00, held_s1};
		nret = (tot > 3'd4) ? 3'd4 : tot;
		use_held = held_s1 && (j_s1 == 2'd0);
		idx = {1'b0, j_s1} - {2'b00, held_s1};
		idx4 = 3'd4 - {2'b00, held_s1};
		is_final = ({1'b0, j_s1} == (nret - 3'd1));
		job_valid = step_v_s1 && ({1'b0, j_s1} < nret);
		fire = job_valid && job_ready;
		done = step_v_s1 && ((nret == 3'd0) || (fire && is_final));
		item_stall = step_v_s1 && !done;
		accept = item_valid && !item_stall;
		held_set = fire && is_final && (tot > 3'd4);
		held_clr = fire && use_held;
		if (held_set) begin
			held_v_d = 1'b1;
		end else if (held_clr) begin
			held_v_d = 1'b0;
		end else begin
			held_v_d = held_v_q;
		end
	end

	always_comb begin
		job = use_held ? held_q : build_job(kinds_s1[idx], sw_q, hs_q, pw_q, hp_q, k_s1);
		job.meta.last = is_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= '0;
			pw_q <= '0;
			pos_q <= '0;
			step_v_s1 <= 1'b0;
			j_s1 <= '0;
			held_v_q <= 1'b0;
		end else begin
			held_v_q <= held_v_d;
			if (accept) begin
				sw_q <= {sw_q[3:0], sample_ext};
				pw_q <= {pw_q[1:0], item.prior_out};
				pos_q <= at_last ? 16'd0 : pos_q + 16'd1;
				step_v_s1 <= 1'b1;
				j_s1 <= '0;
			end else begin
				if (done) begin
					step_v_s1 <= 1'b0;
				end
				if (fire) begin
					j_s1 <= j_s1 + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kinds_s1 <= list;
			n_s1 <= cnt;
			held_s1 <= held_v_d;
			k_s1 <= pos_q;
			if (pos_q < 16'd4) begin
				hs_q[pos_q[1:0]] <= sample_ext;
			end
			if (pos_q < 16'd2) begin
				hp_q[pos_q[0]] <= item.prior_out;
			end
		end
		if (held_set) begin
			held_q <= build_job(kinds_s1[idx4], sw_q, hs_q, pw_q, hp_q, k_s1);
		end
	end

endmodule

// File: hdl/fdld_stencil.sv
// Stencil numerator: weighted operands, then their sum, in two stages.
// Depends on fdld_pkg for job_t and sum_t.
module fdld_stencil (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fdld_pkg::job_t in_job,
	output logic           out_valid,
	input  logic           out_ready,
	output fdld_pkg::sum_t out_sum
);
	import fdld_pkg::*;

	typedef struct packed {
		logic [4:0][39:0] p;
		meta_t            meta;
	} prod_t;

	logic  v_s2;
	prod_t prod_s2;
	logic  v_s3;
	sum_t  sum_s3;
	logic  rdy_s2;
	logic  rdy_s3;
	prod_t prod_d;
	sum_t  sum_d;

	assign rdy_s3 = !v_s3 || out_ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign in_ready = rdy_s2;
	assign out_valid = v_s3;
	assign out_sum = sum_s3;

	always_comb begin
		logic signed [31:0] xs;
		logic signed [6:0]  ws;
		logic signed [39:0] pr;
		prod_d.meta = in_job.meta;
		prod_d.p = '0;
		for (int i = 0; i < STENCIL_TAPS; i++) begin
			xs = $signed(in_job.x[i]);
			ws = $signed(in_job.w[i]);
			pr = 40'(xs) * 40'(ws);
			prod_d.p[i] = pr;
		end
	end

	always_comb begin
		logic signed [39:0] acc;
		acc = '0;
		for (int i = 0; i < STENCIL_TAPS; i++) begin
			acc = acc + $signed(prod_s2.p[i]);
		end
		sum_d.num = acc;
		sum_d.meta = prod_s2.meta;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s2) begin
				v_s2 <= in_valid;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			prod_s2 <= prod_d;
		end
		if (rdy_s3) begin
			sum_s3 <= sum_d;
		end
	end

endmodule

// File: hdl/fdld_scale.sv
// Scaling by the reciprocal: magnitude, split 32-bit products, rounding and
// clamping to 2^40 over three stages. Depends on fdld_pkg.
module fdld_scale (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [31:0]    scale,
	input  logic           in_valid,
	output logic           in_ready,
	input  fdld_pkg::sum_t in_sum,
	output logic           out_valid,
	input  logic           out_ready,
	output fdld_pkg::mag_t out_mag
);
	import fdld_pkg::*;

	typedef struct packed {
		logic [38:0] mag;
		logic        neg;
		meta_t       meta;
	} abs_t;

	typedef struct packed {
		logic [63:0] plo;
		logic [38:0] phi;
		logic        neg;
		meta_t       meta;
	} mul_t;

	logic v_s4;
	logic v_s5;
	logic v_s6;
	abs_t abs_s4;
	mul_t mul_s5;
	mag_t mag_s6;
	logic rdy_s4;
	logic rdy_s5;
	logic rdy_s6;
	abs_t abs_d;
	mul_t mul_d;
	mag_t mag_d;

	assign rdy_s6 = !v_s6 || out_ready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign in_ready = rdy_s4;
	assign out_valid = v_s6;
	assign out_mag = mag_s6;

	always_comb begin
		logic signed [39:0] negated;
		negated = -in_sum.num;
		abs_d.neg = in_sum.num[39];
		abs_d.mag = in_sum.num[39] ? negated[38:0] : in_sum.num[38:0];
		abs_d.meta = in_sum.meta;
	end

	// Low word and high bits of the magnitude are multiplied separately.
	always_comb begin
		logic [31:0] lo;
		logic [6:0]  hi;
		lo = abs_s4.mag[31:0];
		hi = abs_s4.mag[38:32];
		mul_d.plo = {32'd0, lo} * {32'd0, scale};
		mul_d.phi = 39'(hi) * 39'(scale);
		mul_d.neg = abs_s4.neg;
		mul_d.meta = abs_s4.meta;
	end

	// Drop 16 fraction bits, round half away from zero, clamp to 2^40.
	always_comb begin
		logic [49:0] rs;
		rs = (50'(mul_s5.phi[23:0]) << 16) + 50'(mul_s5.plo[63:16]) + 50'(mul_s5.plo[15]);
		if (mul_s5.phi[38:24] != '0) begin
			mag_d.r = R_LIMIT[40:0];
		end else if (rs > R_LIMIT) begin
			mag_d.r = R_LIMIT[40:0];
		end else begin
			mag_d.r = rs[40:0];
		end
		mag_d.neg = mul_s5.neg;
		mag_d.meta = mul_s5.meta;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s4) begin
				v_s4 <= in_valid;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
			if (rdy_s6) begin
				v_s6 <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			abs_s4 <= abs_d;
		end
		if (rdy_s5) begin
			mul_s5 <= mul_d;
		end
		if (rdy_s6) begin
			mag_s6 <= mag_d;
		end
	end

endmodule

// File: hdl/fdld_combine.sv
// Combine with the prior output, saturate to 32 bits and hold the result
// in the output register. Depends on fdld_pkg.
module fdld_combine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        combine_mode,
	input  logic              in_valid,
	output logic              in_ready,
	input  fdld_pkg::mag_t    in_mag,
	output logic              result_valid,
	input  logic              result_stall,
	output fdld_pkg::result_t result
);
	import fdld_pkg::*;

	logic    v_s7;
	result_t res_s7;
	result_t res_d;

	assign in_ready = !v_s7 || !result_stall;
	assign result_valid = v_s7;
	assign result = res_s7;

	// Subtracting the magnitude covers a negative derivative in add mode and
	// a positive one in subtract mode.
	always_comb begin
		logic signed [42:0] base;
		logic signed [42:0] mag_ext;
		logic signed [42:0] total;
		logic               use_prior;
		logic               sub;
		use_prior = (combine_mode == MODE_ADD) || (combine_mode == MODE_SUB);
		sub = in_mag.neg ^ (combine_mode == MODE_SUB);
		base = use_prior ? 43'(in_mag.meta.prior) : '0;
		mag_ext = $signed({2'b00, in_mag.r});
		total = sub ? (base - mag_ext) : (base + mag_ext);
		if (in_mag.meta.err) begin
			res_d.value = '0;
		end else if (total > 43'sd2147483647) begin
			res_d.value = 32'sh7FFF_FFFF;
		end else if (total < -43'sd2147483648) begin
			res_d.value = 32'sh8000_0000;
		end else begin
			res_d.value = total[31:0];
		end
		res_d.position = in_mag.meta.pos;
		res_d.last_of_run = in_mag.meta.last;
		res_d.error = in_mag.meta.err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (in_ready) begin
			v_s7 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			res_s7 <= res_d;
		end
	end

endmodule

// File: hdl/finite_difference_line_derivative.sv
// A result held over from the end of a periodic or short fourth-order line leaves with
// the next item. One item per cycle while each item finishes at most one stencil and
// the stages downstream have room; the issue sequencer sends one result per cycle while
// the stencil stage is ready, and the next item waits until a step's last result has left.
// Reset (arst_n low) clears all control state, the windows and the line position and
// loads the register defaults; head samples are undefined until written, no clearing pass.
module finite_difference_line_derivative (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  fdld_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output fdld_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import fdld_pkg::*;

	cfg_t cfg;

	logic job_valid;
	logic job_ready;
	job_t job;

	logic sum_valid;
	logic sum_ready;
	sum_t sum;

	logic mag_valid;
	logic mag_ready;
	mag_t mag;

	// The configuration registers are written in a transaction of their own and
	// are read live by the front end, the scaling and the combine stages. Writes are
	// expected only while the block is idle, so no stage needs a private copy of them.
	fdld_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The front end shifts each accepted transaction into the sample and prior
	// windows, captures the first samples of a line for periodic wrap, and
	// decodes which stencils the item finishes. Its sequencer issues them one per
	// cycle while the stencil stage has room. A step that finishes five stencils
	// issues four and keeps the fifth until the next item, which sends it first.
	fdld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.job_valid  (job_valid),
		.job_ready  (job_ready),
		.job        (job)
	);

	// The stencil numerator is an exact integer: five small-weight products in
	// one stage and their sum in the next.
	fdld_stencil u_stencil (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (job_valid),
		.in_ready  (job_ready),
		.in_job    (job),
		.out_valid (sum_valid),
		.out_ready (sum_ready),
		.out_sum   (sum)
	);

	// Scaling works on the magnitude so that rounding is symmetric about zero.
	// The magnitude is split at bit 32, giving one 32 by 32 and one 7 by 32
	// product, and the rounded result is clamped to 2^40.
	fdld_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.scale     (cfg.scale),
		.in_valid  (sum_valid),
		.in_ready  (sum_ready),
		.in_sum    (sum),
		.out_valid (mag_valid),
		.out_ready (mag_ready),
		.out_mag   (mag)
	);

	// The last stage applies the combine mode, saturates and forms the output
	// register. Every stage moves whenever the stage after it has room, so while
	// a result waits on a stall the front end takes items until every stage is full.
	fdld_combine u_combine (
		.clk          (clk),
		.arst_n       (arst_n),
		.combine_mode (cfg.combine_mode),
		.in_valid     (mag_valid),
		.in_ready     (mag_ready),
		.in_mag       (mag),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
